>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Transaction kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // update the slot chain and the result registers
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

>>> design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: accepts a transaction, runs its update, raises done.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd,
  output logic      busy,
  output logic      done,
  output logic      was_full,
  output logic      was_empty
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state == ST_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      was_full  <= 1'b0;
      was_empty <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
      if (cmd.exec) begin
        was_full  <= stat.full;
        was_empty <= stat.empty;
      end
    end
  end

endmodule

>>> design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot chain with one comparator per slot, plus result registers.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  spq_cmd_t          cmd,
  input  logic              kind,
  input  logic [PRIO_W-1:0] prio_in,
  input  logic [TAG_W-1:0]  tag_in,
  output spq_stat_t         stat,
  output logic [STAT_W-1:0] status,
  output logic              popped_valid,
  output logic [TAG_W-1:0]  popped_tag,
  output logic [PRIO_W-1:0] popped_prio,
  output logic [OCC_W-1:0]  occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic              kind_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TAG_W-1:0]  tag_q;
  logic [CNT_W-1:0]  count;

  logic [PRIO_W-1:0] slot_prio [DEPTH];
  logic [TAG_W-1:0]  slot_tag  [DEPTH];
  logic [PRIO_W-1:0] prio_next [DEPTH];
  logic [TAG_W-1:0]  tag_next  [DEPTH];
  logic [DEPTH-1:0]  keep;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Each slot compares itself against the new priority. Because the chain is
  // sorted, keep is a prefix of ones that ends at the insertion point.
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign keep[g] = (CNT_W'(g) < count) && (slot_prio[g] >= prio_q);

      always_comb begin
        if (kind_q == KIND_REMOVE) begin
          prio_next[g] = slot_prio[(g < DEPTH - 1) ? g + 1 : g];
          tag_next[g]  = slot_tag[(g < DEPTH - 1) ? g + 1 : g];
        end else if (keep[g]) begin
          prio_next[g] = slot_prio[g];
          tag_next[g]  = slot_tag[g];
        end else if ((g == 0) || keep[(g > 0) ? g - 1 : 0]) begin
          prio_next[g] = prio_q;
          tag_next[g]  = tag_q;
        end else begin
          prio_next[g] = slot_prio[(g > 0) ? g - 1 : 0];
          tag_next[g]  = slot_tag[(g > 0) ? g - 1 : 0];
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.exec && ((kind_q == KIND_REMOVE) ? !stat.empty : !stat.full)) begin
          slot_prio[g] <= prio_next[g];
          slot_tag[g]  <= tag_next[g];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      prio_q  <= prio_in;
      tag_q   <= tag_in;
    end
    if (cmd.exec) begin
      popped_valid <= 1'b0;
      popped_tag   <= '0;
      popped_prio  <= '0;
      status       <= STATUS_OK;
      if (kind_q == KIND_REMOVE) begin
        if (stat.empty) begin
          status <= STATUS_EMPTY;
        end else begin
          popped_valid <= 1'b1;
          popped_tag   <= slot_tag[0];
          popped_prio  <= slot_prio[0];
        end
      end else if (stat.full) begin
        status <= STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (kind_q == KIND_REMOVE && !stat.empty) begin
        count <= count - 1'b1;
      end else if (kind_q == KIND_INSERT && !stat.full) begin
        count <= count + 1'b1;
      end
    end
  end

  assign occupancy = OCC_W'(count);

endmodule

>>> design/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue kept sorted by descending priority, FIFO among ties.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. It is first
// captured into the datapath registers, and then, in the update, every slot
// of the sorted chain compares itself against the new priority in parallel
// and shifts. Busy is high during the update and no transaction is taken
// then; the next can be started once busy falls. The result appears on the
// result ports, marked by a one-cycle done strobe, in the cycle after the
// update; the receiver cannot stall it, so it must capture the result then.
// An insert places the new entry after every stored entry of equal or higher
// priority. A remove on an empty queue reports the empty status and an
// insert on a full queue reports the full status; neither changes the queue.
// The queue starts empty after reset and needs no clearing pass.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [PRIO_W-1:0] prio_in,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic              popped_valid,
  output logic [TAG_W-1:0]  popped_tag,
  output logic [PRIO_W-1:0] popped_prio,
  output logic [OCC_W-1:0]  occupancy
);

  spq_cmd_t  cmd;
  spq_stat_t stat;
  logic      was_full;
  logic      was_empty;
  logic [STAT_W-1:0] dp_status;

  // The controller sequences each transaction.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .was_full  (was_full),
    .was_empty (was_empty)
  );

  // The datapath holds the slot chain and the result registers.
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .prio_in      (prio_in),
    .tag_in       (tag_in),
    .stat         (stat),
    .status       (dp_status),
    .popped_valid (popped_valid),
    .popped_tag   (popped_tag),
    .popped_prio  (popped_prio),
    .occupancy    (occupancy)
  );

  // A refused transaction always saw the queue full or empty; the controller's
  // sampled flags gate the status so a stale code never leaks out.
  assign status = (was_full || was_empty) ? dp_status : STATUS_OK;

endmodule

>>> design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [STAT_W-1:0] status,
  input logic              popped_valid,
  input logic [TAG_W-1:0]  popped_tag,
  input logic [PRIO_W-1:0] popped_prio
);

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not set busy");

  // Every busy cycle is followed by a result.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done) else $error("busy cycle not followed by done");

  // A result never arrives without a transaction: busy must have just fallen.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a transaction");

  // A popped entry always comes with ok status.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    done && popped_valid |-> status == STATUS_OK) else $error("pop with bad status");

  // Results that pop nothing report zero payload.
  a_nopop_zero: assert property (@(posedge clk) disable iff (rst)
    done && !popped_valid |-> popped_tag == '0 && popped_prio == '0)
    else $error("non-pop result carries payload");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (.*);
